// File: hdl/tcbsq_pkg.sv
// Shared types and constants of the two-class byte send queue.
// Used by the front end, back end, core and checker; depends on nothing else.
`default_nettype none

package tcbsq_pkg;

  localparam int QUEUE_DEPTH        = 64;
  localparam int MAX_MESSAGE_LENGTH = 512;
  localparam int NUM_CLASSES        = 2;
  localparam int CMDQ_DEPTH         = 2;
  localparam int RESQ_DEPTH         = 2;

  localparam int ID_W      = 10;
  localparam int LEN_IN_W  = 10;
  localparam int DEL_W     = 16;
  localparam int TOTB_W    = 17;
  localparam int TOTM_W    = 8;
  localparam int OFFSET_W  = 9;
  localparam int REMAIN_W  = 10;

  // Command codes on the input item.
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Classification done by the front end.
  typedef enum logic [2:0] {
    OP_ADD_NORMAL,
    OP_ADD_PRIORITY,
    OP_DELETE,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_STEP,
    BK_LOAD,
    BK_RESULT
  } back_state_t;

  typedef struct packed {
    logic [1:0]          command;
    logic [ID_W-1:0]     message_id;
    logic [LEN_IN_W-1:0] message_length;
    logic                priority_req;
    logic [DEL_W-1:0]    delete_bytes;
  } in_item_t;

  typedef struct packed {
    logic                head_valid;
    logic [ID_W-1:0]     head_id;
    logic [OFFSET_W-1:0] head_offset;
    logic [REMAIN_W-1:0] head_remaining;
    logic                head_is_priority;
    logic [TOTB_W-1:0]   queued_bytes;
    logic [TOTM_W-1:0]   queued_messages;
    logic [DEL_W-1:0]    bytes_removed;
    logic [TOTM_W-1:0]   messages_retired;
    logic                add_rejected;
  } out_item_t;

  typedef struct packed {
    op_t                 op;
    logic [ID_W-1:0]     msg_id;
    logic [LEN_IN_W-1:0] msg_len;
    logic [DEL_W-1:0]    del_bytes;
  } cmd_t;

  // Largest length that is ever stored: the configured maximum, bounded by
  // what the input field can carry.
  function automatic int len_cap(input int max_len);
    int field_max;
    field_max = (2 ** LEN_IN_W) - 1;
    return (max_len > field_max) ? field_max : max_len;
  endfunction

endpackage

`default_nettype wire

// File: hdl/tcbsq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the descriptor stores of the send queue; no dependencies.
`default_nettype none

module tcbsq_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/tcbsq_fifo.sv
// Small register FIFO used for the command queue and the result queue.
// Generic in width and depth; no dependencies.
`default_nettype none

module tcbsq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: hdl/tcbsq_front.sv
// Front end: accepts input items, decodes and classifies them, and queues
// the decoded commands for the back end. Uses tcbsq_pkg and tcbsq_fifo.
`default_nettype none

module tcbsq_front #(
  parameter int MAX_MESSAGE_LENGTH = tcbsq_pkg::MAX_MESSAGE_LENGTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  input  tcbsq_pkg::in_item_t      in_item,
  output logic                     in_full,
  input  wire logic                cmd_pop,
  output tcbsq_pkg::cmd_t          cmd,
  output logic                     cmd_empty
);

  localparam int LEN_CAP = tcbsq_pkg::len_cap(MAX_MESSAGE_LENGTH);

  tcbsq_pkg::cmd_t cmd_in;

  always_comb begin
    cmd_in.msg_id    = in_item.message_id;
    cmd_in.del_bytes = in_item.delete_bytes;
    cmd_in.msg_len   = (32'(in_item.message_length) > LEN_CAP) ?
                       tcbsq_pkg::LEN_IN_W'(LEN_CAP) : in_item.message_length;
    unique case (in_item.command)
      tcbsq_pkg::CMD_ADD: begin
        cmd_in.op = in_item.priority_req ? tcbsq_pkg::OP_ADD_PRIORITY
                                         : tcbsq_pkg::OP_ADD_NORMAL;
      end
      // A delete of zero bytes reports exactly like a no-op.
      tcbsq_pkg::CMD_DELETE: begin
        cmd_in.op = (in_item.delete_bytes == '0) ? tcbsq_pkg::OP_NOP
                                                 : tcbsq_pkg::OP_DELETE;
      end
      tcbsq_pkg::CMD_CLEAR: begin
        cmd_in.op = tcbsq_pkg::OP_CLEAR;
      end
      default: begin
        cmd_in.op = tcbsq_pkg::OP_NOP;
      end
    endcase
  end

  tcbsq_fifo #(
    .WIDTH ($bits(tcbsq_pkg::cmd_t)),
    .DEPTH (tcbsq_pkg::CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

endmodule

`default_nettype wire

// File: hdl/tcbsq_back.sv
// Back end: executes decoded commands on the two descriptor classes and
// builds one result item per command. Uses tcbsq_pkg and tcbsq_ram.
`default_nettype none

module tcbsq_back #(
  parameter int QUEUE_DEPTH        = tcbsq_pkg::QUEUE_DEPTH,
  parameter int MAX_MESSAGE_LENGTH = tcbsq_pkg::MAX_MESSAGE_LENGTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  tcbsq_pkg::cmd_t     cmd,
  input  wire logic           cmd_empty,
  output logic                cmd_pop,
  output tcbsq_pkg::out_item_t res,
  output logic                res_push,
  input  wire logic           res_full
);

  localparam int NC      = tcbsq_pkg::NUM_CLASSES;
  localparam int AW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW      = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_CAP = tcbsq_pkg::len_cap(MAX_MESSAGE_LENGTH);
  localparam int LW      = $clog2(LEN_CAP + 1);
  localparam int DW      = tcbsq_pkg::ID_W + LW;
  localparam int BW      = tcbsq_pkg::TOTB_W;
  localparam int MW      = tcbsq_pkg::TOTM_W;
  localparam int DLW     = tcbsq_pkg::DEL_W;

  tcbsq_pkg::back_state_t state_r, state_nxt;

  logic [AW-1:0]               rd_r   [NC];
  logic [AW-1:0]               rd_nxt [NC];
  logic [AW-1:0]               wr_r   [NC];
  logic [AW-1:0]               wr_nxt [NC];
  logic [CW-1:0]               cnt_r  [NC];
  logic [CW-1:0]               cnt_nxt[NC];
  logic [LW-1:0]               sent_r [NC];
  logic [LW-1:0]               sent_nxt[NC];
  logic [tcbsq_pkg::ID_W-1:0]  hid_r  [NC];
  logic [tcbsq_pkg::ID_W-1:0]  hid_nxt[NC];
  logic [LW-1:0]               hlen_r [NC];
  logic [LW-1:0]               hlen_nxt[NC];
  logic [BW-1:0]               tot_b_r, tot_b_nxt;
  logic [MW-1:0]               tot_m_r, tot_m_nxt;
  logic [DLW-1:0]              want_r, want_nxt;
  logic [DLW-1:0]              del_r, del_nxt;
  logic [MW-1:0]               retired_r, retired_nxt;
  logic                        rej_r, rej_nxt;
  logic                        cls_r, cls_nxt;

  logic                        has_head;
  logic                        hsel;
  logic                        cls;
  logic [AW-1:0]               rd_adv;
  logic [AW-1:0]               wr_adv;
  logic [LW-1:0]               left;
  logic [LW-1:0]               len_in;
  logic [15:0]                 off_wide;
  logic                        ram_we;
  logic [DW-1:0]               ram_wdata;
  logic [DW-1:0]               ram_rdata[NC];

  // The head to send: a partly sent normal head first, then priority,
  // then normal.
  always_comb begin
    priority if ((cnt_r[0] != '0) && (sent_r[0] != '0)) begin
      has_head = 1'b1;
      hsel     = 1'b0;
    end else if (cnt_r[1] != '0) begin
      has_head = 1'b1;
      hsel     = 1'b1;
    end else if (cnt_r[0] != '0) begin
      has_head = 1'b1;
      hsel     = 1'b0;
    end else begin
      has_head = 1'b0;
      hsel     = 1'b0;
    end
  end

  // While idle the class follows the incoming add, otherwise the head.
  assign cls    = (state_r == tcbsq_pkg::BK_IDLE) ?
                  (cmd.op == tcbsq_pkg::OP_ADD_PRIORITY) : hsel;
  assign rd_adv = (rd_r[cls] == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_r[cls] + AW'(1);
  assign wr_adv = (wr_r[cls] == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_r[cls] + AW'(1);
  assign left   = hlen_r[cls] - sent_r[cls];
  assign len_in = LW'(cmd.msg_len);
  assign ram_wdata = {cmd.msg_id, len_in};
  assign off_wide  = 16'(sent_r[cls]);

  for (genvar g = 0; g < NC; g++) begin : g_class
    tcbsq_ram #(
      .WIDTH (DW),
      .DEPTH (QUEUE_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we && (cls == 1'(g))),
      .waddr (wr_r[cls]),
      .wdata (ram_wdata),
      .raddr (rd_adv),
      .rdata (ram_rdata[g])
    );
  end

  always_comb begin
    state_nxt   = state_r;
    rd_nxt      = rd_r;
    wr_nxt      = wr_r;
    cnt_nxt     = cnt_r;
    sent_nxt    = sent_r;
    hid_nxt     = hid_r;
    hlen_nxt    = hlen_r;
    tot_b_nxt   = tot_b_r;
    tot_m_nxt   = tot_m_r;
    want_nxt    = want_r;
    del_nxt     = del_r;
    retired_nxt = retired_r;
    rej_nxt     = rej_r;
    cls_nxt     = cls_r;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    ram_we      = 1'b0;

    unique case (state_r)
      tcbsq_pkg::BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop     = 1'b1;
          want_nxt    = '0;
          del_nxt     = '0;
          retired_nxt = '0;
          rej_nxt     = 1'b0;
          state_nxt   = tcbsq_pkg::BK_RESULT;
          unique case (cmd.op)
            tcbsq_pkg::OP_ADD_NORMAL, tcbsq_pkg::OP_ADD_PRIORITY: begin
              if (cnt_r[cls] == CW'(QUEUE_DEPTH)) begin
                rej_nxt = 1'b1;
              end else begin
                ram_we       = 1'b1;
                wr_nxt[cls]  = wr_adv;
                cnt_nxt[cls] = cnt_r[cls] + CW'(1);
                // An empty class takes its head descriptor straight away.
                if (cnt_r[cls] == '0) begin
                  hid_nxt[cls]  = cmd.msg_id;
                  hlen_nxt[cls] = len_in;
                end
                tot_b_nxt = tot_b_r + BW'(len_in);
                tot_m_nxt = tot_m_r + MW'(1);
              end
            end
            tcbsq_pkg::OP_DELETE: begin
              want_nxt  = cmd.del_bytes;
              del_nxt   = cmd.del_bytes;
              state_nxt = tcbsq_pkg::BK_STEP;
            end
            tcbsq_pkg::OP_CLEAR: begin
              rd_nxt    = '{default: '0};
              wr_nxt    = '{default: '0};
              cnt_nxt   = '{default: '0};
              sent_nxt  = '{default: '0};
              tot_b_nxt = '0;
              tot_m_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      tcbsq_pkg::BK_STEP: begin
        priority if ((want_r == '0) || !has_head) begin
          state_nxt = tcbsq_pkg::BK_RESULT;
        end else if (want_r >= DLW'(left)) begin
          // The whole head message goes; fetch the next descriptor if any.
          want_nxt      = want_r - DLW'(left);
          retired_nxt   = retired_r + MW'(1);
          tot_b_nxt     = tot_b_r - BW'(left);
          tot_m_nxt     = tot_m_r - MW'(1);
          cnt_nxt[cls]  = cnt_r[cls] - CW'(1);
          sent_nxt[cls] = '0;
          rd_nxt[cls]   = rd_adv;
          cls_nxt       = cls;
          if (cnt_r[cls] != CW'(1)) begin
            state_nxt = tcbsq_pkg::BK_LOAD;
          end
        end else begin
          want_nxt      = '0;
          sent_nxt[cls] = sent_r[cls] + LW'(want_r);
          tot_b_nxt     = tot_b_r - BW'(want_r);
          state_nxt     = tcbsq_pkg::BK_RESULT;
        end
      end

      tcbsq_pkg::BK_LOAD: begin
        {hid_nxt[cls_r], hlen_nxt[cls_r]} = ram_rdata[cls_r];
        state_nxt = tcbsq_pkg::BK_STEP;
      end

      tcbsq_pkg::BK_RESULT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = tcbsq_pkg::BK_IDLE;
        end
      end

      default: begin
        state_nxt = tcbsq_pkg::BK_IDLE;
      end
    endcase
  end

  always_comb begin
    res.head_valid       = has_head;
    res.head_id          = '0;
    res.head_offset      = '0;
    res.head_remaining   = '0;
    res.head_is_priority = 1'b0;
    if (has_head) begin
      res.head_id          = hid_r[cls];
      res.head_offset      = off_wide[tcbsq_pkg::OFFSET_W-1:0];
      res.head_remaining   = tcbsq_pkg::REMAIN_W'(left);
      res.head_is_priority = cls;
    end
    res.queued_bytes     = tot_b_r;
    res.queued_messages  = tot_m_r;
    res.bytes_removed    = del_r - want_r;
    res.messages_retired = retired_r;
    res.add_rejected     = rej_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcbsq_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r    <= '{default: '0};
      wr_r    <= '{default: '0};
      cnt_r   <= '{default: '0};
      sent_r  <= '{default: '0};
      tot_b_r <= '0;
      tot_m_r <= '0;
    end else begin
      rd_r    <= rd_nxt;
      wr_r    <= wr_nxt;
      cnt_r   <= cnt_nxt;
      sent_r  <= sent_nxt;
      tot_b_r <= tot_b_nxt;
      tot_m_r <= tot_m_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hid_r     <= hid_nxt;
    hlen_r    <= hlen_nxt;
    want_r    <= want_nxt;
    del_r     <= del_nxt;
    retired_r <= retired_nxt;
    rej_r     <= rej_nxt;
    cls_r     <= cls_nxt;
  end

endmodule

`default_nettype wire

// File: hdl/two_class_byte_send_queue_core.sv
// Send queue with a normal and a priority class of message descriptors.
// Items are queued on the input side and each command gives one result
// item on the output side; both sides behave as FIFOs, and a two-entry
// command queue and a two-entry result queue let the producer and the
// consumer stall independently of the executing logic. An add, clear,
// unknown command or delete of zero bytes moves the back end from idle to
// its result state. Any other delete also passes through the step state,
// which retires one message at a time, and, while the class holds more, a
// load state that reads the next head descriptor from that class's
// descriptor RAM, whose registered read port needs it. The result state
// repeats while the result queue is full. The descriptor RAMs need no
// initialization after reset. Uses tcbsq_pkg, front, back and fifo.
`default_nettype none

module two_class_byte_send_queue_core #(
  parameter int QUEUE_DEPTH        = tcbsq_pkg::QUEUE_DEPTH,
  parameter int MAX_MESSAGE_LENGTH = tcbsq_pkg::MAX_MESSAGE_LENGTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  input  tcbsq_pkg::in_item_t   in_item,
  output logic                  in_full,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output tcbsq_pkg::out_item_t  out_item
);

  tcbsq_pkg::cmd_t      cmd;
  logic                 cmd_empty;
  logic                 cmd_pop;
  tcbsq_pkg::out_item_t res;
  logic                 res_push;
  logic                 res_full;

  tcbsq_front #(
    .MAX_MESSAGE_LENGTH (MAX_MESSAGE_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  tcbsq_back #(
    .QUEUE_DEPTH        (QUEUE_DEPTH),
    .MAX_MESSAGE_LENGTH (MAX_MESSAGE_LENGTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res       (res),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  tcbsq_fifo #(
    .WIDTH ($bits(tcbsq_pkg::out_item_t)),
    .DEPTH (tcbsq_pkg::RESQ_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

endmodule

`default_nettype wire

// File: hdl/tcbsq_checker.sv
// Port-level checks of the two-class byte send queue, bound to the top.
// Depends on tcbsq_pkg and two_class_byte_send_queue_core.
`default_nettype none

module tcbsq_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_full,
  input wire logic            out_empty,
  input wire logic            out_pop,
  input tcbsq_pkg::out_item_t out_item
);

  // Reset leaves no result waiting and room for new items.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // A waiting result that is not taken stays on the ports unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty && $stable(out_item))
    else $error("waiting result changed before it was taken");

  // Without a head, all head fields read zero.
  a_no_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_item.head_valid) |->
      (out_item.head_id == '0) && (out_item.head_offset == '0) &&
      (out_item.head_remaining == '0) && !out_item.head_is_priority)
    else $error("head fields set while no head is valid");

  // An empty queue holds no bytes and no messages.
  a_empty_totals: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_item.head_valid) |->
      (out_item.queued_bytes == '0) && (out_item.queued_messages == '0))
    else $error("totals nonzero with no message queued");

  // A rejected add never reports removed bytes or retired messages.
  a_reject_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.add_rejected) |->
      (out_item.bytes_removed == '0) && (out_item.messages_retired == '0))
    else $error("rejected add reports delete results");

endmodule

bind two_class_byte_send_queue_core tcbsq_checker u_chk (.*);

`default_nettype wire
